/* hw/rtl/hsv2rgb_pkg.sv */
package hsv2rgb_pkg;

  // Channel precision. Saturation, brightness and the outputs are fractions of MaxV.
  localparam int ChannelBits = 8;
  localparam int MaxV        = (1 << ChannelBits) - 1;

  // Hue is carried in whole degrees.
  localparam int HueW      = 9;
  localparam int HueWrap   = 360;
  localparam int SectorDeg = 60;
  localparam int RemW      = $clog2(SectorDeg);

  // Common denominator of the q and t terms.
  localparam int DenQ  = SectorDeg * MaxV;
  localparam int DenQW = $clog2(DenQ + 1);

  // Width of the rounded q and t numerators, v * (DenQ - s * f) + DenQ / 2.
  localparam int NumW = ChannelBits + DenQW;

  // Division by DenQ is a multiply by a rounded-up reciprocal followed by a shift.
  // The shift is long enough for the quotient to be exact over the whole
  // numerator range.
  localparam int RecipShift = NumW + DenQW + 1;
  localparam int RecipW     = RecipShift - DenQW + 1;
  localparam int ProdW      = NumW + RecipW;
  localparam longint unsigned RecipMulL =
      ((64'd1 << RecipShift) + 64'(DenQ) - 64'd1) / 64'(DenQ);
  localparam logic [RecipW-1:0] RecipMul = RecipW'(RecipMulL);

  // Hue sector, sixty degrees each, named by the colors at its ends.
  typedef enum logic [2:0] {
    SecRedYellow,
    SecYellowGreen,
    SecGreenCyan,
    SecCyanBlue,
    SecBlueMagenta,
    SecMagentaRed
  } sector_e;

endpackage

/* hw/rtl/hsv2rgb_rdiv.sv */
module hsv2rgb_rdiv (
  input  logic                                clk_i,
  input  logic [hsv2rgb_pkg::NumW-1:0]        num_i,
  output logic [hsv2rgb_pkg::ChannelBits-1:0] quo_o
);

  // One multiply by the reciprocal; the quotient sits above the shift point.
  logic [hsv2rgb_pkg::ProdW-1:0]       prod;
  logic [hsv2rgb_pkg::ChannelBits-1:0] quo_q;

  assign prod = hsv2rgb_pkg::ProdW'(num_i) * hsv2rgb_pkg::ProdW'(hsv2rgb_pkg::RecipMul);

  always_ff @(posedge clk_i) begin
    quo_q <= prod[hsv2rgb_pkg::RecipShift +: hsv2rgb_pkg::ChannelBits];
  end

  assign quo_o = quo_q;

endmodule

/* hw/rtl/hsv_to_rgb_converter.sv */
// HSV to RGB color converter. One color word is taken per clock: a word is
// accepted on any rising edge with start_i high, and busy_o stays low because
// every stage advances on every clock. The matching RGB word appears on red_o,
// green_o and blue_o, marked by a one-cycle valid_o pulse; the receiver cannot
// stall, so it must take each word in the cycle it is shown. The result is
// registered through the stage chain: hue reduction, the term products, the
// numerator products, the reciprocal multiply that divides by sixty times full
// scale, and the sector mux in the output register. Hue is in whole degrees;
// 360 and above wrap by subtracting 360 once. A zero saturation gives gray
// equal to the brightness. Each term is rounded half up to the nearest
// channel code.
module hsv_to_rgb_converter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [hsv2rgb_pkg::HueW-1:0]        hue_i,
  input  logic [hsv2rgb_pkg::ChannelBits-1:0] saturation_i,
  input  logic [hsv2rgb_pkg::ChannelBits-1:0] brightness_i,
  output logic                                valid_o,
  output logic [hsv2rgb_pkg::ChannelBits-1:0] red_o,
  output logic [hsv2rgb_pkg::ChannelBits-1:0] green_o,
  output logic [hsv2rgb_pkg::ChannelBits-1:0] blue_o
);

  localparam int Cb   = hsv2rgb_pkg::ChannelBits;
  localparam int HueW = hsv2rgb_pkg::HueW;
  localparam int RemW = hsv2rgb_pkg::RemW;
  localparam int Sd   = hsv2rgb_pkg::SectorDeg;

  // The pipeline never holds off the sender.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage 1: wrap the hue and split it into sector and remainder.
  // ---------------------------------------------------------------------------
  logic [HueW-1:0]      hue_red;
  logic [HueW-1:0]      sec_base;
  hsv2rgb_pkg::sector_e sector_d;

  always_comb begin
    if (hue_i >= HueW'(hsv2rgb_pkg::HueWrap)) begin
      hue_red = hue_i - HueW'(hsv2rgb_pkg::HueWrap);
    end else begin
      hue_red = hue_i;
    end
    if (hue_red < HueW'(Sd)) begin
      sector_d = hsv2rgb_pkg::SecRedYellow;
      sec_base = '0;
    end else if (hue_red < HueW'(2 * Sd)) begin
      sector_d = hsv2rgb_pkg::SecYellowGreen;
      sec_base = HueW'(Sd);
    end else if (hue_red < HueW'(3 * Sd)) begin
      sector_d = hsv2rgb_pkg::SecGreenCyan;
      sec_base = HueW'(2 * Sd);
    end else if (hue_red < HueW'(4 * Sd)) begin
      sector_d = hsv2rgb_pkg::SecCyanBlue;
      sec_base = HueW'(3 * Sd);
    end else if (hue_red < HueW'(5 * Sd)) begin
      sector_d = hsv2rgb_pkg::SecBlueMagenta;
      sec_base = HueW'(4 * Sd);
    end else begin
      sector_d = hsv2rgb_pkg::SecMagentaRed;
      sec_base = HueW'(5 * Sd);
    end
  end

  logic                 s1_valid_q;
  hsv2rgb_pkg::sector_e s1_sector_q;
  logic [RemW-1:0]      s1_rem_q;
  logic [Cb-1:0]        s1_sat_q;
  logic [Cb-1:0]        s1_val_q;

  always_ff @(posedge clk_i) begin
    s1_sector_q <= sector_d;
    s1_rem_q    <= RemW'(hue_red - sec_base);
    s1_sat_q    <= saturation_i;
    s1_val_q    <= brightness_i;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the first products. p needs v * (1 - S); q and t need S * f and
  // S * (1 - f), both scaled by sixty.
  // ---------------------------------------------------------------------------
  logic                 s2_valid_q;
  hsv2rgb_pkg::sector_e s2_sector_q;
  logic [Cb-1:0]        s2_val_q;
  logic [2*Cb-1:0]      s2_pn_q;
  logic [Cb+RemW-1:0]   s2_sq_q;
  logic [Cb+RemW-1:0]   s2_st_q;
  logic [RemW-1:0]      rem_inv;

  assign rem_inv = RemW'(Sd) - s1_rem_q;

  always_ff @(posedge clk_i) begin
    s2_sector_q <= s1_sector_q;
    s2_val_q    <= s1_val_q;
    s2_pn_q     <= (2*Cb)'(s1_val_q) * (2*Cb)'(Cb'(hsv2rgb_pkg::MaxV) - s1_sat_q);
    s2_sq_q     <= (Cb+RemW)'(s1_sat_q) * (Cb+RemW)'(s1_rem_q);
    s2_st_q     <= (Cb+RemW)'(s1_sat_q) * (Cb+RemW)'(rem_inv);
  end

  // ---------------------------------------------------------------------------
  // Stage 3: rounded numerators of q and t, and the finished p term. Division
  // of p by full scale uses the 2^n - 1 identity, exact over the whole range.
  // ---------------------------------------------------------------------------
  localparam int DqW = hsv2rgb_pkg::DenQW;
  localparam int NmW = hsv2rgb_pkg::NumW;

  logic [DqW-1:0]  q_fac;
  logic [DqW-1:0]  t_fac;
  logic [2*Cb-1:0] p_num;
  logic [2*Cb:0]   p_sum;

  assign q_fac = DqW'(hsv2rgb_pkg::DenQ) - DqW'(s2_sq_q);
  assign t_fac = DqW'(hsv2rgb_pkg::DenQ) - DqW'(s2_st_q);
  assign p_num = s2_pn_q + (2*Cb)'(hsv2rgb_pkg::MaxV / 2);
  assign p_sum = (2*Cb+1)'(p_num) + (2*Cb+1)'(p_num >> Cb) + (2*Cb+1)'(1);

  logic                 s3_valid_q;
  hsv2rgb_pkg::sector_e s3_sector_q;
  logic [Cb-1:0]        s3_val_q;
  logic [Cb-1:0]        s3_p_q;
  logic [NmW-1:0]       s3_qn_q;
  logic [NmW-1:0]       s3_tn_q;

  always_ff @(posedge clk_i) begin
    s3_sector_q <= s2_sector_q;
    s3_val_q    <= s2_val_q;
    s3_p_q      <= p_sum[Cb +: Cb];
    s3_qn_q     <= NmW'(s2_val_q) * NmW'(q_fac) + NmW'(hsv2rgb_pkg::DenQ / 2);
    s3_tn_q     <= NmW'(s2_val_q) * NmW'(t_fac) + NmW'(hsv2rgb_pkg::DenQ / 2);
  end

  // ---------------------------------------------------------------------------
  // Stage 4: divide q and t by sixty times full scale.
  // ---------------------------------------------------------------------------
  logic [Cb-1:0] q_term;
  logic [Cb-1:0] t_term;

  hsv2rgb_rdiv u_div_q (
    .clk_i (clk_i),
    .num_i (s3_qn_q),
    .quo_o (q_term)
  );

  hsv2rgb_rdiv u_div_t (
    .clk_i (clk_i),
    .num_i (s3_tn_q),
    .quo_o (t_term)
  );

  logic                 s4_valid_q;
  hsv2rgb_pkg::sector_e s4_sector_q;
  logic [Cb-1:0]        s4_val_q;
  logic [Cb-1:0]        s4_p_q;

  always_ff @(posedge clk_i) begin
    s4_sector_q <= s3_sector_q;
    s4_val_q    <= s3_val_q;
    s4_p_q      <= s3_p_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: route the terms to the channels by sector. With zero saturation
  // every term equals the brightness, so gray needs no separate path.
  // ---------------------------------------------------------------------------
  logic [Cb-1:0] red_d;
  logic [Cb-1:0] green_d;
  logic [Cb-1:0] blue_d;

  always_comb begin
    case (s4_sector_q)
      hsv2rgb_pkg::SecRedYellow: begin
        red_d = s4_val_q; green_d = t_term;   blue_d = s4_p_q;
      end
      hsv2rgb_pkg::SecYellowGreen: begin
        red_d = q_term;   green_d = s4_val_q; blue_d = s4_p_q;
      end
      hsv2rgb_pkg::SecGreenCyan: begin
        red_d = s4_p_q;   green_d = s4_val_q; blue_d = t_term;
      end
      hsv2rgb_pkg::SecCyanBlue: begin
        red_d = s4_p_q;   green_d = q_term;   blue_d = s4_val_q;
      end
      hsv2rgb_pkg::SecBlueMagenta: begin
        red_d = t_term;   green_d = s4_p_q;   blue_d = s4_val_q;
      end
      default: begin
        red_d = s4_val_q; green_d = s4_p_q;   blue_d = q_term;
      end
    endcase
  end

  logic          valid_q;
  logic [Cb-1:0] red_q;
  logic [Cb-1:0] green_q;
  logic [Cb-1:0] blue_q;

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  // Valid bits travel alongside the data through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      s1_valid_q <= start_i && !busy_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      valid_q    <= s4_valid_q;
    end
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

`ifndef SYNTHESIS
  // Every accepted word comes out, marked by valid_o.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##5 valid_o)
    else $error("accepted word did not appear after five cycles");

  // Zero saturation gives gray at the input brightness.
  a_gray : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && saturation_i == '0) |-> ##5
      (red_o == $past(brightness_i, 5) && green_o == $past(brightness_i, 5) &&
       blue_o == $past(brightness_i, 5)))
    else $error("zero saturation did not give gray");

  // The largest channel always equals the brightness.
  a_max_channel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##5
      (red_o == $past(brightness_i, 5) || green_o == $past(brightness_i, 5) ||
       blue_o == $past(brightness_i, 5)))
    else $error("no channel carries the brightness");

  // No channel exceeds the brightness.
  a_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##5
      (red_o <= $past(brightness_i, 5) && green_o <= $past(brightness_i, 5) &&
       blue_o <= $past(brightness_i, 5)))
    else $error("channel above brightness");
`endif

endmodule

/* sim/tb_hsv_to_rgb_converter.sv */
module tb_hsv_to_rgb_converter;

  localparam int ChannelBits = hsv2rgb_pkg::ChannelBits;
  localparam int HueW        = hsv2rgb_pkg::HueW;
  localparam int HueWrap     = hsv2rgb_pkg::HueWrap;
  localparam int SectorDeg   = hsv2rgb_pkg::SectorDeg;

  // One RGB word as the converter shows it on its result ports.
  typedef struct packed {
    logic [ChannelBits-1:0] red;
    logic [ChannelBits-1:0] green;
    logic [ChannelBits-1:0] blue;
  } rgb_t;

  // One row of the directed part. Where typed is set, rgb holds the color
  // that can be read off by hand; otherwise the row is checked against the
  // converter model below.
  typedef struct packed {
    logic [HueW-1:0]        hue;
    logic [ChannelBits-1:0] sat;
    logic [ChannelBits-1:0] val;
    logic                   typed;
    rgb_t                   rgb;
  } hsv_row_t;

  localparam int NumDirected  = 22;
  localparam int NumRandom    = 1000;
  localparam int MaxReports   = 10;
  // Longest stretch without a word moving on either side: the longest gap of
  // the sender plus the pipeline depth, taken many times over.
  localparam int StallLimit   = 500;
  // Quiet cycles after the last expected word, to catch any stray result.
  localparam int DrainCycles  = 12;
  localparam int FullScale    = hsv2rgb_pkg::MaxV;

  // The directed part: gray at both ends and past the hue range, the pure
  // primaries and secondaries at every sector start, hue wrap at 360 and
  // above, black from zero brightness, and the edges of every sector.
  localparam hsv_row_t DirectedRows [NumDirected] = '{
    '{9'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0  }},
    '{9'd123, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{9'd511, 8'd0,   8'd128, 1'b1, '{8'd128, 8'd128, 8'd128}},
    '{9'd0,   8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0  }},
    '{9'd60,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0  }},
    '{9'd120, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0  }},
    '{9'd180, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{9'd240, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{9'd300, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{9'd360, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0  }},
    '{9'd420, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0  }},
    '{9'd200, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0  }},
    '{9'd511, 8'd255, 8'd255, 1'b0, '0},
    '{9'd361, 8'd200, 8'd180, 1'b0, '0},
    '{9'd359, 8'd255, 8'd255, 1'b0, '0},
    '{9'd59,  8'd170, 8'd255, 1'b0, '0},
    '{9'd61,  8'd170, 8'd255, 1'b0, '0},
    '{9'd119, 8'd1,   8'd255, 1'b0, '0},
    '{9'd179, 8'd255, 8'd1,   1'b0, '0},
    '{9'd239, 8'd128, 8'd127, 1'b0, '0},
    '{9'd299, 8'd85,  8'd200, 1'b0, '0},
    '{9'd30,  8'd254, 8'd254, 1'b0, '0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic [HueW-1:0]        hue_i;
  logic [ChannelBits-1:0] saturation_i;
  logic [ChannelBits-1:0] brightness_i;
  logic                   valid_o;
  logic [ChannelBits-1:0] red_o;
  logic [ChannelBits-1:0] green_o;
  logic [ChannelBits-1:0] blue_o;

  // Colors owed by the converter, oldest first.
  rgb_t pending_rgb [$];
  rgb_t oldest_rgb;
  int   mismatch_count;
  int   quiet_cycles;
  int   burst_left;

  hsv_to_rgb_converter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .valid_o      (valid_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned round_half_up(longint unsigned num,
                                                    longint unsigned den);
    return (num + den / 2) / den;
  endfunction

  // Converter model. Every term is formed exactly in 64-bit integers and
  // rounded half up, so the result is bit exact with no floating point.
  function automatic rgb_t rgb_of_hsv(logic [HueW-1:0] hue,
                                      logic [ChannelBits-1:0] sat,
                                      logic [ChannelBits-1:0] val);
    longint unsigned      h;
    longint unsigned      s;
    longint unsigned      v;
    longint unsigned      rem;
    longint unsigned      den;
    longint unsigned      p;
    longint unsigned      q;
    longint unsigned      t;
    hsv2rgb_pkg::sector_e sector;
    rgb_t                 c;
    h = hue;
    s = sat;
    v = val;
    // A single subtract folds 360..511 back into the circle.
    if (h >= HueWrap) h = h - HueWrap;
    if (s == 0) begin
      c = '{val, val, val};
      return c;
    end
    sector = hsv2rgb_pkg::sector_e'(3'(h / SectorDeg));
    rem    = h % SectorDeg;
    den    = SectorDeg * FullScale;
    p = round_half_up(v * (FullScale - s), FullScale);
    q = round_half_up(v * (den - s * rem), den);
    t = round_half_up(v * (den - s * (SectorDeg - rem)), den);
    case (sector)
      hsv2rgb_pkg::SecRedYellow:   c = '{val, t[ChannelBits-1:0], p[ChannelBits-1:0]};
      hsv2rgb_pkg::SecYellowGreen: c = '{q[ChannelBits-1:0], val, p[ChannelBits-1:0]};
      hsv2rgb_pkg::SecGreenCyan:   c = '{p[ChannelBits-1:0], val, t[ChannelBits-1:0]};
      hsv2rgb_pkg::SecCyanBlue:    c = '{p[ChannelBits-1:0], q[ChannelBits-1:0], val};
      hsv2rgb_pkg::SecBlueMagenta: c = '{t[ChannelBits-1:0], p[ChannelBits-1:0], val};
      default:                     c = '{val, p[ChannelBits-1:0], q[ChannelBits-1:0]};
    endcase
    return c;
  endfunction

  // Presents one HSV word from the falling edge on and holds it until a rising
  // edge sees start high with busy low. The owed color is queued at that edge.
  task automatic send_hsv(logic [HueW-1:0] hue, logic [ChannelBits-1:0] sat,
                          logic [ChannelBits-1:0] val, rgb_t want);
    @(negedge clk_i);
    start_i      <= 1'b1;
    hue_i        <= hue;
    saturation_i <= sat;
    brightness_i <= val;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_rgb.push_back(want);
  endtask

  // Keeps start low for a number of cycles while the data ports carry noise,
  // which the converter must ignore.
  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start_i      <= 1'b0;
      hue_i        <= HueW'($urandom);
      saturation_i <= ChannelBits'($urandom);
      brightness_i <= ChannelBits'($urandom);
    end
  endtask

  // Gap before the next word. Bursts with no gap at all alternate with
  // stretches of mostly short and now and then long gaps, so that idle
  // cycles land on every stage of the pipeline.
  function automatic int pick_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Hue mostly on the circle, weighted toward sector edges, with a share of
  // the out-of-range codes 361..511 that wrap by a single subtract.
  function automatic logic [HueW-1:0] pick_hue();
    int roll;
    int h;
    roll = $urandom_range(0, 99);
    if (roll < 10) return HueW'($urandom_range(HueWrap + 1, (1 << HueW) - 1));
    if (roll < 25) begin
      h = SectorDeg * $urandom_range(0, 6) + $urandom_range(0, 2) - 1;
      if (h < 0) h = 0;
      return HueW'(h);
    end
    return HueW'($urandom_range(0, HueWrap));
  endfunction

  // Channel code with extra weight on zero, one and full scale.
  function automatic logic [ChannelBits-1:0] pick_channel();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 18) return ChannelBits'(FullScale);
    if (roll < 23) return ChannelBits'(1);
    return ChannelBits'($urandom);
  endfunction

  task automatic note_mismatch(string what, rgb_t want);
    mismatch_count++;
    if (mismatch_count <= MaxReports)
      $display("MISMATCH %s: expected rgb %0d %0d %0d, got %0d %0d %0d",
               what, want.red, want.green, want.blue, red_o, green_o, blue_o);
  endtask

  // Every strobed result is taken in the cycle it is shown and compared field
  // by field with the oldest color still owed.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && valid_o === 1'b1) begin
      if (pending_rgb.size() == 0) begin
        note_mismatch("result with no word pending", '0);
      end else begin
        oldest_rgb = pending_rgb.pop_front();
        if (red_o !== oldest_rgb.red || green_o !== oldest_rgb.green ||
            blue_o !== oldest_rgb.blue)
          note_mismatch("channel value", oldest_rgb);
      end
    end
  end

  // Watchdog: ends the run when neither side has moved a word for too long.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((start_i === 1'b1 && busy_o === 1'b0) || valid_o === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("hsv_to_rgb_converter verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [HueW-1:0]        hue;
    logic [ChannelBits-1:0] sat;
    logic [ChannelBits-1:0] val;
    rgb_t                   want;
    mismatch_count = 0;
    quiet_cycles   = 0;
    burst_left     = 0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    hue_i          = '0;
    saturation_i   = '0;
    brightness_i   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: typed-in colors where they are obvious, the model
    // elsewhere. Every row goes back to back except for a random gap.
    foreach (DirectedRows[i]) begin
      if (DirectedRows[i].typed)
        want = DirectedRows[i].rgb;
      else
        want = rgb_of_hsv(DirectedRows[i].hue, DirectedRows[i].sat,
                          DirectedRows[i].val);
      send_hsv(DirectedRows[i].hue, DirectedRows[i].sat, DirectedRows[i].val,
               want);
      hold_off(pick_gap());
    end

    // Random words, checked against the model.
    repeat (NumRandom) begin
      hue = pick_hue();
      sat = pick_channel();
      val = pick_channel();
      send_hsv(hue, sat, val, rgb_of_hsv(hue, sat, val));
      hold_off(pick_gap());
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    // The watchdog bounds this wait if results stop coming.
    while (pending_rgb.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && pending_rgb.size() == 0) begin
      $display("hsv_to_rgb_converter verification clean");
    end else begin
      $display("hsv_to_rgb_converter verification failed");
    end
    $finish;
  end

endmodule
